@@ rtl/ccrc_pkg.sv @@
// ============================================================================
// ccrc_pkg - shared types and constants for the programmable CRC-32 engine
// Holds the mode codes, register indexes and the configuration bundle.
// ============================================================================
`default_nettype none

package ccrc_pkg;

    localparam int unsigned CrcWidth  = 32;
    localparam int unsigned ByteWidth = 8;

    localparam logic [CrcWidth-1:0] ResetPoly  = 32'h04C1_1DB7;
    localparam logic [CrcWidth-1:0] Crc32cPoly = 32'h82F6_3B78;
    localparam logic [CrcWidth-1:0] ResetInit  = 32'h0000_0000;
    localparam logic [CrcWidth-1:0] ResetFxor  = 32'h0000_0000;

    // Fold algorithm; the unused code falls back to the direct form.
    typedef enum logic [1:0] {
        MODE_AUGMENTED = 2'd0,
        MODE_DIRECT    = 2'd1,
        MODE_REFLECTED = 2'd2,
        MODE_SPARE     = 2'd3
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_POLY = 2'd0,
        CFG_INIT = 2'd1,
        CFG_FXOR = 2'd2,
        CFG_MODE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CrcWidth-1:0] poly;
        logic [CrcWidth-1:0] init;
        logic [CrcWidth-1:0] fxor;
        t_mode               mode;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/configurable_crc32_engine_core.sv @@
// ============================================================================
// configurable_crc32_engine_core - programmable CRC-32 over a byte stream
// Byte input register, combinational fold, registered result with stall support.
// ============================================================================
// Path: a last byte goes from the input register through the fold into the result
//   register on o_crc_result (two-stage); a full, stalled result slot holds it back.
// Throughput: one byte per cycle unless o_in_stall holds a last byte; set by the
//   running-CRC loop, which closes combinationally through the eight-round fold.
// Reset: synchronous, active low; clears valids and the message-in-progress
//   flag and restores the register defaults. No clearing pass is needed.
`default_nettype none

module configurable_crc32_engine_core
    import ccrc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_crc_result,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    t_cfg cfg;

    // Configuration is always taken; the sender must write only while the datapath
    // is idle, which the block itself does not enforce.
    assign o_cfg_ready = 1'b1;

    ccrc_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // Input stage: hold the accepted byte until it is folded.
    // ------------------------------------------------------------------
    logic                 r_in_valid;
    logic [ByteWidth-1:0] r_in_byte;
    logic                 r_in_last;

    // Running state of the message in progress.
    logic                 r_mid;
    logic [CrcWidth-1:0]  r_running;

    // Result stage.
    logic                 r_out_valid;
    logic [CrcWidth-1:0]  r_out_crc;

    logic                 in_take;
    logic                 out_take;
    logic                 fold_go;
    logic [CrcWidth-1:0]  fold_seed;
    logic [CrcWidth-1:0]  fold_crc;

    assign out_take = r_out_valid && !i_out_stall;

    // Fold the held byte when it needs no result slot, or the slot is
    // empty or being drained this cycle.
    assign fold_go = r_in_valid && (!r_in_last || !r_out_valid || !i_out_stall);

    // Stall only when the held byte cannot advance.
    assign o_in_stall = r_in_valid && !fold_go;
    assign in_take    = i_in_valid && !o_in_stall;

    // A new message starts from the init register as it stands now.
    assign fold_seed = r_mid ? r_running : cfg.init;

    ccrc_fold u_fold (
        .i_crc  (fold_seed),
        .i_byte (r_in_byte),
        .i_poly (cfg.poly),
        .i_mode (cfg.mode),
        .o_crc  (fold_crc)
    );

    // Input register: load on accept, drop once folded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fold_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Running CRC: advance on every fold, restart after a last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
        end else if (fold_go) begin
            r_mid <= !r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fold_go) begin
            r_running <= fold_crc;
        end
    end

    // Result register: load the finished CRC on a last byte, clear on drain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fold_go && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fold_go && r_in_last) begin
            r_out_crc <= fold_crc ^ cfg.fxor;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_crc_result = r_out_crc;

endmodule

`default_nettype wire

@@ rtl/ccrc_regs.sv @@
// ============================================================================
// ccrc_regs - configuration register file
// Holds polynomial, init, final xor and mode; written one word per handshake.
// ============================================================================
`default_nettype none

module ccrc_regs
    import ccrc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_POLY: n_cfg.poly = i_cfg_data;
                CFG_INIT: n_cfg.init = i_cfg_data;
                CFG_FXOR: n_cfg.fxor = i_cfg_data;
                CFG_MODE: n_cfg.mode = t_mode'(i_cfg_data[1:0]);
                default:  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poly <= ResetPoly;
            r_cfg.init <= ResetInit;
            r_cfg.fxor <= ResetFxor;
            r_cfg.mode <= MODE_DIRECT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/ccrc_fold.sv @@
// ============================================================================
// ccrc_fold - one-byte CRC fold
// Eight unrolled XOR-shift rounds in the form selected by the mode.
// ============================================================================
`default_nettype none

module ccrc_fold
    import ccrc_pkg::*;
(
    input  wire logic [CrcWidth-1:0]  i_crc,
    input  wire logic [ByteWidth-1:0] i_byte,
    input  wire logic [CrcWidth-1:0]  i_poly,
    input  t_mode                     i_mode,
    output logic [CrcWidth-1:0]       o_crc
);

    logic [CrcWidth-1:0] augm;
    logic [CrcWidth-1:0] dirc;
    logic [CrcWidth-1:0] refl;

    always_comb begin
        augm = i_crc;
        dirc = i_crc;
        refl = i_crc ^ {{(CrcWidth-ByteWidth){1'b0}}, i_byte};
        for (int k = 0; k < ByteWidth; k++) begin
            // augmented: message bit enters at the low end
            augm = {augm[CrcWidth-2:0], i_byte[ByteWidth-1-k]}
                 ^ (augm[CrcWidth-1] ? i_poly : '0);
            // direct: feedback is top bit xor message bit
            dirc = {dirc[CrcWidth-2:0], 1'b0}
                 ^ ((dirc[CrcWidth-1] ^ i_byte[ByteWidth-1-k]) ? i_poly : '0);
            // reflected: shift right with the fixed polynomial
            refl = {1'b0, refl[CrcWidth-1:1]} ^ (refl[0] ? Crc32cPoly : '0);
        end
    end

    always_comb begin
        unique case (i_mode)
            MODE_AUGMENTED: o_crc = augm;
            MODE_REFLECTED: o_crc = refl;
            MODE_DIRECT:    o_crc = dirc;
            default:        o_crc = dirc;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/ccrc_checker.sv @@
// ============================================================================
// ccrc_checker - port-level checks for the CRC engine
// Watches handshakes and result timing; attached to the top level by bind.
// ============================================================================
`default_nettype none

module ccrc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        i_last_byte,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_crc_result
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_crc_result))
        else $error("stalled result changed or dropped");

    // Stall the input only behind a full, stalled result slot.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without backpressure");

    // A result rising into an empty slot comes from an accepted last byte: into the
    // input register, then through the fold into the result register.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall && i_last_byte, 2))
        else $error("result without an accepted last byte");

    // Come out of reset with no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && ($past(i_rst_n) == 1'b0) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind configurable_crc32_engine_core ccrc_checker u_ccrc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_last_byte  (i_last_byte),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_crc_result (o_crc_result)
);

`default_nettype wire
